@@ design/rmts_pkg.sv @@
// Shared types and constants for the rate-monotonic tick scheduler.
package rmts_pkg;

  // Widths of the fixed port fields.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned IDENT_W  = 8;

  // Command codes carried by an input word.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic restart;
    logic scan_start;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_idx;
  } ctrl_sts_t;

endpackage

@@ design/rmts_ctrl.sv @@
// Controller state machine of the rate-monotonic tick scheduler.
module rmts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  rmts_pkg::op_e      op_i,
  input  rmts_pkg::ctrl_sts_t sts_i,
  output rmts_pkg::ctrl_cmd_t cmd_o,
  output logic               busy
);
  import rmts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && op_i == OP_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.last_idx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load       = (op_i == OP_LOAD);
          cmd_o.restart    = (op_i == OP_RESTART);
          cmd_o.scan_start = (op_i == OP_TICK);
        end
      end
      ST_SCAN:   cmd_o.issue  = 1'b1;
      ST_DRAIN:  cmd_o.commit = 1'b0;
      ST_COMMIT: cmd_o.commit = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

endmodule

@@ design/rmts_datapath.sv @@
// Slot tables, scan pipeline and priority pick of the tick scheduler.
module rmts_datapath #(
  parameter int unsigned MAX_TASKS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmts_pkg::ctrl_cmd_t           cmd_i,
  output rmts_pkg::ctrl_sts_t           sts_o,
  input  logic [rmts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [rmts_pkg::FIELD_W-1:0]  period_i,
  input  logic [rmts_pkg::FIELD_W-1:0]  budget_i,
  input  logic [rmts_pkg::IDENT_W-1:0]  task_ident_i,
  input  logic                          enable_i,
  output logic                          result_valid_o,
  output logic [rmts_pkg::IDENT_W-1:0]  running_ident_o,
  output logic                          idle_o,
  output logic [rmts_pkg::SLOT_W-1:0]   running_slot_o
);
  import rmts_pkg::*;

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Slot tables: static fields written by load, dynamic ones by the scan and commit.
  logic [TIME_BITS-1:0] period_mem [MAX_TASKS];
  logic [TIME_BITS-1:0] budget_mem [MAX_TASKS];
  logic [IDENT_W-1:0]   ident_mem  [MAX_TASKS];
  logic [TIME_BITS-1:0] rem_mem    [MAX_TASKS];
  logic [TIME_BITS-1:0] phase_mem  [MAX_TASKS];

  // Per-slot flags: enabled, and phase forced to zero by load or restart.
  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [MAX_TASKS-1:0] fresh_q, fresh_d;

  logic [IDX_W-1:0]     rd_idx_q, proc_idx_q;
  logic                 proc_vld_q;
  logic [TIME_BITS-1:0] rd_period_q, rd_budget_q, rd_rem_q, rd_phase_q;
  logic [IDENT_W-1:0]   rd_ident_q;

  logic                 best_found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [TIME_BITS-1:0] best_period_q, best_rem_q, best_phase_q;
  logic [IDENT_W-1:0]   best_ident_q;

  logic                 res_valid_q;
  logic [IDENT_W-1:0]   res_ident_q;
  logic                 res_idle_q;
  logic [SLOT_W-1:0]    res_slot_q;

  logic                 ld_ok;
  logic [IDX_W-1:0]     ld_idx;
  logic [TIME_BITS-1:0] cur_phase, cur_rem, next_phase;
  logic [TIME_BITS:0]   phase_inc;
  logic                 slot_live, take;
  logic                 wb_en;
  logic [IDX_W-1:0]     wb_idx;
  logic [TIME_BITS-1:0] wb_rem, wb_phase;

  assign ld_ok  = cmd_i.load && (int'(slot_i) < int'(MAX_TASKS));
  assign ld_idx = IDX_W'(slot_i);

  assign sts_o.last_idx = (rd_idx_q == IDX_W'(MAX_TASKS - 1));

  // Evaluate the slot read in the previous cycle.
  always_comb begin
    cur_phase  = fresh_q[proc_idx_q] ? '0 : rd_phase_q;
    cur_rem    = (cur_phase == '0) ? rd_budget_q : rd_rem_q;
    phase_inc  = {1'b0, cur_phase} + (TIME_BITS+1)'(1);
    next_phase = (phase_inc >= {1'b0, rd_period_q}) ? '0 : phase_inc[TIME_BITS-1:0];
    slot_live  = proc_vld_q && valid_q[proc_idx_q];
    take       = slot_live && (cur_rem != '0) &&
                 (!best_found_q || (rd_period_q < best_period_q));
  end

  // Write back either the scanned slot or the decremented winner.
  always_comb begin
    if (cmd_i.commit) begin
      wb_en    = best_found_q;
      wb_idx   = best_idx_q;
      wb_rem   = best_rem_q - TIME_BITS'(1);
      wb_phase = best_phase_q;
    end else begin
      wb_en    = slot_live;
      wb_idx   = proc_idx_q;
      wb_rem   = cur_rem;
      wb_phase = next_phase;
    end
  end

  always_comb begin
    valid_d = valid_q;
    fresh_d = fresh_q;
    if (ld_ok) begin
      valid_d[ld_idx] = enable_i;
      fresh_d[ld_idx] = 1'b1;
    end
    if (cmd_i.restart) begin
      fresh_d = '1;
    end
    if (slot_live) begin
      fresh_d[proc_idx_q] = 1'b0;
    end
  end

  // Static table: write on load, read along the scan.
  always_ff @(posedge clk_i) begin
    if (ld_ok) begin
      period_mem[ld_idx] <= TIME_BITS'(period_i);
      budget_mem[ld_idx] <= TIME_BITS'(budget_i);
      ident_mem[ld_idx]  <= task_ident_i;
    end
    if (cmd_i.issue) begin
      rd_period_q <= period_mem[rd_idx_q];
      rd_budget_q <= budget_mem[rd_idx_q];
      rd_ident_q  <= ident_mem[rd_idx_q];
    end
  end

  // Dynamic table: remaining budget and phase.
  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      rem_mem[wb_idx]   <= wb_rem;
      phase_mem[wb_idx] <= wb_phase;
    end
    if (cmd_i.issue) begin
      rd_rem_q   <= rem_mem[rd_idx_q];
      rd_phase_q <= phase_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      fresh_q      <= '1;
      rd_idx_q     <= '0;
      proc_idx_q   <= '0;
      proc_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      fresh_q    <= fresh_d;
      proc_vld_q <= cmd_i.issue;
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.issue) begin
        rd_idx_q   <= rd_idx_q + IDX_W'(1);
        proc_idx_q <= rd_idx_q;
      end
      if (cmd_i.scan_start) begin
        best_found_q <= 1'b0;
      end else if (take) begin
        best_found_q <= 1'b1;
      end
      res_valid_q <= cmd_i.commit;
    end
  end

  // Winner payload and result word.
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q    <= proc_idx_q;
      best_period_q <= rd_period_q;
      best_rem_q    <= cur_rem;
      best_phase_q  <= next_phase;
      best_ident_q  <= rd_ident_q;
    end
    if (cmd_i.commit) begin
      res_ident_q <= best_found_q ? best_ident_q : '0;
      res_idle_q  <= !best_found_q;
      res_slot_q  <= best_found_q ? SLOT_W'(best_idx_q) : '0;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign running_ident_o = res_ident_q;
  assign idle_o          = res_idle_q;
  assign running_slot_o  = res_slot_q;

endmodule

@@ design/rate_monotonic_tick_scheduler_top.sv @@
// Top level of the rate-monotonic tick scheduler.
//
// Rate-monotonic tick scheduler over MAX_TASKS periodic task slots. A word
// is taken when start is high and busy is low. A load word (op 0) writes one
// slot's period, budget, identifier and enable bit and restarts that slot's
// phase; a slot number at or above MAX_TASKS is dropped. A restart word
// (op 2) returns every phase to time zero. Op 3 is ignored. A tick word
// (op 1) keeps busy high while the controller walks the slot tables one
// slot per cycle through a registered read port, reloading budgets at
// period boundaries, advancing phases and keeping the ready slot with the
// smallest period (lower slot on ties), then drains the read pipeline and
// charges the winner. The result word appears on the cycle after that, held
// for exactly one cycle with result_valid_o high; the receiver cannot stall
// it, and the next word may be taken in that same cycle. An idle tick
// reports idle_o 1 with identifier and slot zero. Load and restart words
// produce no result. Counters are TIME_BITS wide; period and budget are
// cut to that width.
module rate_monotonic_tick_scheduler_top #(
  parameter int unsigned MAX_TASKS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rmts_pkg::OP_W-1:0]     op_i,
  input  logic [rmts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [rmts_pkg::FIELD_W-1:0]  period_i,
  input  logic [rmts_pkg::FIELD_W-1:0]  budget_i,
  input  logic [rmts_pkg::IDENT_W-1:0]  task_ident_i,
  input  logic                          enable_i,
  output logic                          result_valid_o,
  output logic [rmts_pkg::IDENT_W-1:0]  running_ident_o,
  output logic                          idle_o,
  output logic [rmts_pkg::SLOT_W-1:0]   running_slot_o
);
  import rmts_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  op_e       op;

  // Decode the command code; unused codes map onto the no-op member.
  always_comb begin
    unique case (op_i)
      OP_LOAD:    op = OP_LOAD;
      OP_TICK:    op = OP_TICK;
      OP_RESTART: op = OP_RESTART;
      default:    op = OP_NONE;
    endcase
  end

  // Sequence the scan: idle, walk slots, drain, charge winner.
  rmts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Hold slot tables, evaluate each slot and track the best candidate.
  rmts_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .slot_i          (slot_i),
    .period_i        (period_i),
    .budget_i        (budget_i),
    .task_ident_i    (task_ident_i),
    .enable_i        (enable_i),
    .result_valid_o  (result_valid_o),
    .running_ident_o (running_ident_o),
    .idle_o          (idle_o),
    .running_slot_o  (running_slot_o)
  );

endmodule

@@ design/rmts_checker.sv @@
// Port-level checks for the rate-monotonic tick scheduler, bound to the top.
module rmts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [rmts_pkg::OP_W-1:0]     op_i,
  input logic                          result_valid_o,
  input logic [rmts_pkg::IDENT_W-1:0]  running_ident_o,
  input logic                          idle_o,
  input logic [rmts_pkg::SLOT_W-1:0]   running_slot_o
);
  import rmts_pkg::*;

  // An accepted tick occupies the block on the next cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_TICK) |=> busy)
    else $error("tick word taken but block not busy");

  // An idle result carries zero identifier and slot.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && idle_o) |-> (running_ident_o == '0 && running_slot_o == '0))
    else $error("idle result with nonzero payload");

  // Each tick yields one strobe; strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe repeated");

  // A result follows a busy cycle, the end of a tick's scan.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding tick work");

  // Load and restart words give no result.
  a_no_result_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i != OP_TICK) |=> !result_valid_o)
    else $error("result after non-tick word");

endmodule

bind rate_monotonic_tick_scheduler_top rmts_checker u_rmts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .op_i            (op_i),
  .result_valid_o  (result_valid_o),
  .running_ident_o (running_ident_o),
  .idle_o          (idle_o),
  .running_slot_o  (running_slot_o)
);

@@ verif/testbench.sv @@
// Testbench for the rate-monotonic tick scheduler: directed and random words, scoreboard check.
`timescale 1ns / 1ps

module testbench;
  import rmts_pkg::*;

  // Keep the slot count and counter width in step with the instance below.
  localparam int unsigned SLOTS        = 8;
  localparam int unsigned TIME_W       = 16;
  // A tick keeps busy high through scan, drain and commit, then the result follows.
  localparam int unsigned TICK_LATENCY = SLOTS + 4;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_LIMIT = 10;

  // One tick outcome: who ran, or idle.
  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic               idle;
    logic [SLOT_W-1:0]  slot;
  } tick_outcome_t;

  // Shadow of the slot tables; predicts every tick and checks the outcome.
  class tick_scoreboard;
    logic [TIME_W-1:0]  period_tbl    [SLOTS];
    logic [TIME_W-1:0]  budget_tbl    [SLOTS];
    logic [IDENT_W-1:0] ident_tbl     [SLOTS];
    logic               live_tbl      [SLOTS];
    logic [TIME_W-1:0]  remaining_tbl [SLOTS];
    logic [TIME_W-1:0]  phase_tbl     [SLOTS];
    tick_outcome_t      due_runs[$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        period_tbl[i]    = '0;
        budget_tbl[i]    = '0;
        ident_tbl[i]     = '0;
        live_tbl[i]      = 1'b0;
        remaining_tbl[i] = '0;
        phase_tbl[i]     = '0;
      end
      mismatches = 0;
    endfunction

    // Reload at boundaries, pick the shortest ready period, charge it, advance phases.
    function tick_outcome_t run_tick();
      int            pick;
      tick_outcome_t r;
      logic [TIME_W:0] nxt;
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (live_tbl[i]) begin
          if (phase_tbl[i] == '0) remaining_tbl[i] = budget_tbl[i];
          if (remaining_tbl[i] != '0 &&
              (pick < 0 || period_tbl[i] < period_tbl[pick])) pick = i;
        end
      end
      if (pick >= 0) begin
        remaining_tbl[pick] = remaining_tbl[pick] - 1'b1;
        r.ident = ident_tbl[pick];
        r.idle  = 1'b0;
        r.slot  = SLOT_W'(pick);
      end else begin
        r = '0;
        r.idle = 1'b1;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (live_tbl[i]) begin
          nxt = {1'b0, phase_tbl[i]} + 1'b1;
          if (nxt >= {1'b0, period_tbl[i]}) nxt = '0;
          phase_tbl[i] = nxt[TIME_W-1:0];
        end
      end
      return r;
    endfunction

    // Apply one accepted word to the shadow state; queue the tick outcome.
    function void note_word(op_e op, logic [SLOT_W-1:0] slot, logic [FIELD_W-1:0] period,
                            logic [FIELD_W-1:0] budget, logic [IDENT_W-1:0] ident,
                            logic en);
      case (op)
        OP_LOAD: begin
          if (slot < SLOTS) begin
            period_tbl[slot]    = period[TIME_W-1:0];
            budget_tbl[slot]    = budget[TIME_W-1:0];
            ident_tbl[slot]     = ident;
            live_tbl[slot]      = en;
            phase_tbl[slot]     = '0;
            remaining_tbl[slot] = '0;
          end
        end
        OP_TICK: due_runs.push_back(run_tick());
        OP_RESTART: begin
          for (int i = 0; i < SLOTS; i++) phase_tbl[i] = '0;
        end
        default: ;
      endcase
    endfunction

    // Compare one result word with the oldest queued outcome.
    function void check_result(tick_outcome_t got);
      tick_outcome_t want;
      if (due_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: ident %0h idle %0b slot %0d",
                   got.ident, got.idle, got.slot);
        return;
      end
      want = due_runs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("expected ident %0h idle %0b slot %0d, got ident %0h idle %0b slot %0d",
                   want.ident, want.idle, want.slot, got.ident, got.idle, got.slot);
      end
    endfunction

    function int unsigned pending();
      return due_runs.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     op_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [FIELD_W-1:0]  period_i;
  logic [FIELD_W-1:0]  budget_i;
  logic [IDENT_W-1:0]  task_ident_i;
  logic                enable_i;
  logic                result_valid_o;
  logic [IDENT_W-1:0]  running_ident_o;
  logic                idle_o;
  logic [SLOT_W-1:0]   running_slot_o;

  tick_scoreboard board;
  int unsigned    cycles;

  rate_monotonic_tick_scheduler_top #(
    .MAX_TASKS(SLOTS),
    .TIME_BITS(TIME_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .slot_i         (slot_i),
    .period_i       (period_i),
    .budget_i       (budget_i),
    .task_ident_i   (task_ident_i),
    .enable_i       (enable_i),
    .result_valid_o (result_valid_o),
    .running_ident_o(running_ident_o),
    .idle_o         (idle_o),
    .running_slot_o (running_slot_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sample at the rising edge: check the result first, then note any word
  // taken at this edge. Outputs still hold their pre-edge values here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_result({running_ident_o, idle_o, running_slot_o});
      if (start && !busy)
        board.note_word(op_e'(op_i), slot_i, period_i, budget_i, task_ident_i, enable_i);
    end
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one word at the falling edge and hold it until the block takes it.
  task automatic send_word(op_e op, logic [SLOT_W-1:0] slot, logic [FIELD_W-1:0] period,
                           logic [FIELD_W-1:0] budget, logic [IDENT_W-1:0] ident,
                           logic en);
    @(negedge clk_i);
    start        <= 1'b1;
    op_i         <= op;
    slot_i       <= slot;
    period_i     <= period;
    budget_i     <= budget;
    task_ident_i <= ident;
    enable_i     <= en;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Tick with junk in the unused fields: the block must ignore them.
  task automatic send_tick();
    send_word(OP_TICK, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
              IDENT_W'($urandom), 1'($urandom));
  endtask

  // Drop start for a burst of cycles.
  task automatic hold_off(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Load a random slot; mostly short periods and small budgets so slots
  // cycle through many boundaries, sometimes the full field range.
  task automatic send_random_load();
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] budget;
    period = ($urandom_range(0, 3) != 0) ? FIELD_W'($urandom_range(0, 12))
                                         : FIELD_W'($urandom);
    budget = ($urandom_range(0, 3) != 0) ? FIELD_W'($urandom_range(0, 4))
                                         : FIELD_W'($urandom);
    send_word(OP_LOAD, SLOT_W'($urandom), period, budget, IDENT_W'($urandom),
              ($urandom_range(0, 6) != 0));
  endtask

  initial begin
    int unsigned counted;
    int unsigned pick;
    bit          gaps_on;

    board        = new();
    cycles       = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = OP_NONE;
    slot_i       = '0;
    period_i     = '0;
    budget_i     = '0;
    task_ident_i = '0;
    enable_i     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table gives an idle tick; the unused op is dropped.
    send_tick();
    send_word(OP_NONE, 3'd5, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    // Longest period with full budget in slot 0; period zero in slot 7 ranks
    // first; budget zero in slot 3 is never ready; slots 1 and 2 tie on
    // period so the lower slot wins; slot 4 is loaded disabled.
    send_word(OP_LOAD, 3'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_word(OP_LOAD, 3'd7, 16'h0000, 16'h0001, 8'h00, 1'b1);
    send_word(OP_LOAD, 3'd3, 16'h0001, 16'h0000, 8'h3C, 1'b1);
    send_word(OP_LOAD, 3'd1, 16'h0005, 16'h0002, 8'h11, 1'b1);
    send_word(OP_LOAD, 3'd2, 16'h0005, 16'h0002, 8'h22, 1'b1);
    send_word(OP_LOAD, 3'd4, 16'h0001, 16'h0005, 8'hAA, 1'b0);
    repeat (6) send_tick();
    // Restart mid-period: phases return to zero, budgets reload next tick.
    send_word(OP_RESTART, 3'd2, 16'h1234, 16'h4321, 8'h5A, 1'b1);
    repeat (3) send_tick();
    // Disable the period-zero slot.
    send_word(OP_LOAD, 3'd7, 16'h0000, 16'h0000, 8'h00, 1'b0);
    repeat (3) send_tick();

    // Random: mostly ticks over a churning table, some restarts and noise.
    counted = 0;
    gaps_on = 1'b1;
    while (counted < RANDOM_WORDS) begin
      // Re-roll the idling mode now and then so some stretches run flat out.
      if (counted % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (gaps_on && counted < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 4) == 0)
        hold_off($urandom_range(1, 19));
      // Halfway through, hold off until every tick has reported.
      if (counted == RANDOM_WORDS / 2) begin
        hold_off(1);
        while (board.pending() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_tick();
        counted++;
      end else if (pick < 90) begin
        send_random_load();
        counted++;
      end else if (pick < 96) begin
        send_word(OP_RESTART, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                  IDENT_W'($urandom), 1'($urandom));
        counted++;
      end else begin
        send_word(OP_NONE, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                  IDENT_W'($urandom), 1'($urandom));
      end
    end
    hold_off(1);

    // Drain: wait for every outstanding tick, then watch for stray results.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2 * TICK_LATENCY) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
